@@ design/uds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uds_pkg
// Shared types of the display sanitiser: controller states, and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package uds_pkg;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CHECK,
		S_FA,
		S_FD,
		S_DEC,
		S_SA,
		S_SD,
		S_RUNEND,
		S_RA,
		S_RD,
		S_ENC,
		S_DONE,
		S_OA,
		S_OL,
		S_OW,
		S_FAIL
	} uds_state_t;

	typedef struct packed {
		logic load;
		logic conv_init;
		logic fetch_cap;
		logic dec_step;
		logic scan_step;
		logic run_end;
		logic run_ld;
		logic enc_step;
		logic out_ld;
		logic fail_ld;
		logic out_next;
		logic out_done;
	} uds_cmd_t;

	typedef struct packed {
		logic overrun;
		logic dec_go;
		logic fetch_done;
		logic dec_cont;
		logic scan_go;
		logic in_run;
		logic pt_arabic;
		logic pt_space;
		logic enc_full;
		logic enc_last;
		logic ridx_zero;
		logic ol_zero;
		logic out_is_last;
		logic out_fire;
	} uds_sts_t;

endpackage

@@ design/uds_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uds_ctrl
// Sequencer of the sanitiser: loading, decoding, run shaping, encoding and
// delivery of the output words.
// ----------------------------------------------------------------------------
module uds_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last_byte,
	output logic            in_stall,
	output uds_pkg::uds_cmd_t cmd,
	input  uds_pkg::uds_sts_t sts
);
	import uds_pkg::*;

	uds_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid && last_byte) state_nx = S_CHECK;
			end
			S_CHECK:  state_nx = sts.overrun ? S_FAIL : S_FA;
			S_FA:     state_nx = sts.dec_go ? S_FD : S_SA;
			S_FD:     state_nx = sts.fetch_done ? S_DEC : S_FA;
			S_DEC:    state_nx = sts.dec_cont ? S_DEC : S_FA;
			S_SA: begin
				if (sts.scan_go) state_nx = S_SD;
				else if (sts.in_run) state_nx = S_RUNEND;
				else state_nx = S_DONE;
			end
			S_SD: begin
				if (sts.in_run) begin
					state_nx = (sts.pt_arabic || sts.pt_space) ? S_SA : S_RUNEND;
				end else begin
					state_nx = sts.pt_arabic ? S_SA : S_ENC;
				end
			end
			S_RUNEND: state_nx = S_RA;
			S_RA:     state_nx = S_RD;
			S_RD:     state_nx = S_ENC;
			S_ENC: begin
				if (sts.enc_full) state_nx = S_FAIL;
				else if (sts.enc_last) begin
					if (sts.in_run && !sts.ridx_zero) state_nx = S_RA;
					else state_nx = S_SA;
				end
			end
			S_DONE:   state_nx = sts.ol_zero ? S_FAIL : S_OA;
			S_OA:     state_nx = S_OL;
			S_OL:     state_nx = S_OW;
			S_OW: begin
				if (sts.out_fire) state_nx = sts.out_is_last ? S_LOAD : S_OA;
			end
			S_FAIL:   state_nx = S_OW;
			default:  state_nx = S_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_CHECK:  cmd.conv_init = 1'b1;
			S_FD:     cmd.fetch_cap = 1'b1;
			S_DEC:    cmd.dec_step = 1'b1;
			S_SD:     cmd.scan_step = 1'b1;
			S_RUNEND: cmd.run_end = 1'b1;
			S_RD:     cmd.run_ld = 1'b1;
			S_ENC:    cmd.enc_step = 1'b1;
			S_OL:     cmd.out_ld = 1'b1;
			S_FAIL:   cmd.fail_ld = 1'b1;
			S_OW: begin
				cmd.out_next = sts.out_fire && !sts.out_is_last;
				cmd.out_done = sts.out_fire && sts.out_is_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ design/uds_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uds_dp
// Datapath of the sanitiser: raw byte store, decoder window, code point
// store, run shaper, shaped run store, UTF-8 encoder and output buffer.
// ----------------------------------------------------------------------------
module uds_dp #(
	parameter int LINE_MAX  = 64,
	parameter int RAW_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  uds_pkg::uds_cmd_t cmd,
	output uds_pkg::uds_sts_t sts,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic              failed,
	output logic              out_valid,
	input  logic              out_stall
);
	import uds_pkg::*;

	localparam int CW = $clog2(RAW_BYTES + 1);
	localparam int AW = $clog2(RAW_BYTES);
	localparam int PW = $clog2(LINE_MAX);
	localparam logic [PW-1:0] LIM  = PW'(LINE_MAX - 1);
	localparam logic [CW-1:0] RAWN = CW'(RAW_BYTES);
	localparam logic [20:0] QMARK = 21'h3F;
	localparam logic [20:0] SPACE = 21'h20;

	localparam logic [15:0] AR_ISO [36] = '{
		16'hFE80, 16'hFE81, 16'hFE83, 16'hFE85, 16'hFE87, 16'hFE89, 16'hFE8D, 16'hFE8F,
		16'hFE93, 16'hFE95, 16'hFE99, 16'hFE9D, 16'hFEA1, 16'hFEA5, 16'hFEA9, 16'hFEAB,
		16'hFEAD, 16'hFEAF, 16'hFEB1, 16'hFEB5, 16'hFEB9, 16'hFEBD, 16'hFEC1, 16'hFEC5,
		16'hFEC9, 16'hFECD, 16'hFED1, 16'hFED5, 16'hFED9, 16'hFEDD, 16'hFEE1, 16'hFEE5,
		16'hFEE9, 16'hFEED, 16'hFEEF, 16'hFEF1
	};

	function automatic logic in_font(input logic [20:0] c);
		return (c >= 21'h20 && c <= 21'h7E) || (c >= 21'h80 && c <= 21'h24F) ||
			(c >= 21'h370 && c <= 21'h4FF) || (c >= 21'h3000 && c <= 21'h30FF) ||
			(c >= 21'h4E00 && c <= 21'h9FEF) || (c >= 21'h20000 && c <= 21'h200CC) ||
			(c >= 21'hAC00 && c <= 21'hD7A3) || (c >= 21'h600 && c <= 21'h6FF) ||
			(c >= 21'h750 && c <= 21'h77F) || (c >= 21'h8A0 && c <= 21'h8FF) ||
			(c >= 21'hFB50 && c <= 21'hFDFF) || (c >= 21'hFE70 && c <= 21'hFEFF);
	endfunction

	function automatic logic [20:0] font_fix(input logic [20:0] c);
		return in_font(c) ? c : QMARK;
	endfunction

	function automatic logic cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic logic nf4(input logic [5:0] k);
		logic r;
		unique case (k) inside
			6'd5, 6'd7, [6'd9:6'd13], [6'd18:6'd32], 6'd35: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] sub_len(input logic [7:0] b);
		logic [1:0] r;
		unique case (b) inside
			8'h80, 8'h85: r = 2'd3;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sub_char(input logic [7:0] b, input logic [1:0] j);
		logic [7:0] r;
		unique case (b) inside
			8'h80: begin
				if (j == 2'd0) r = "E";
				else if (j == 2'd1) r = "U";
				else r = "R";
			end
			8'h82: r = ",";
			8'h83: r = "f";
			8'h84, 8'h93, 8'h94: r = 8'h22;
			8'h85: r = ".";
			8'h86, 8'h87: r = "+";
			8'h89: r = "%";
			8'h8B, 8'h9B: r = "<";
			8'h91, 8'h92: r = 8'h27;
			8'h96, 8'h97: r = "-";
			default: r = "?";
		endcase
		return r;
	endfunction

	function automatic logic [1:0] enc_len(input logic [20:0] c);
		logic [1:0] r;
		if (c < 21'h80) r = 2'd0;
		else if (c < 21'h800) r = 2'd1;
		else if (c < 21'h10000) r = 2'd2;
		else r = 2'd3;
		return r;
	endfunction

	function automatic logic [7:0] enc_byte(input logic [20:0] c, input logic [1:0] l,
		input logic [1:0] j);
		logic [7:0] r;
		logic [1:0] k;
		k = l - j;
		if (j == 2'd0) begin
			unique case (l)
				2'd0: r = c[7:0];
				2'd1: r = {3'b110, c[10:6]};
				2'd2: r = {4'b1110, c[15:12]};
				default: r = {5'b11110, c[20:18]};
			endcase
		end else begin
			unique case (k)
				2'd0: r = {2'b10, c[5:0]};
				2'd1: r = {2'b10, c[11:6]};
				default: r = {2'b10, c[17:12]};
			endcase
		end
		return r;
	endfunction

	function automatic logic [20:0] shape(input logic [5:0] k, input logic cp, input logic cn);
		logic [15:0] off;
		off = (cp && cn) ? 16'd3 : cp ? 16'd1 : cn ? 16'd2 : 16'd0;
		return {5'b0, AR_ISO[k] + off};
	endfunction

	logic [7:0]  raw_mem [RAW_BYTES];
	logic [20:0] pt_mem [LINE_MAX];
	logic [20:0] sh_mem [LINE_MAX];
	logic [7:0]  ob_mem [LINE_MAX];
	logic [7:0]  raw_rd_q, ob_rd_q;
	logic [20:0] pt_rd_q, sh_rd_q;

	logic [CW-1:0] cnt_q, pos_q;
	logic          overrun_q;
	logic [1:0]    fk_q, sub_q, bidx_q;
	logic [2:0]    nav_q;
	logic [PW-1:0] np_q, i_q, rl_q, ridx_q, ol_q, oi_q, ppos_q;
	logic          in_run_q, out_valid_q;
	logic [7:0]    w_q [4];
	logic [5:0]    pk_q;
	logic          pcp_q;
	logic [20:0]   enc_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q, failed_q;

	logic          raw_we, pt_we, sh_we, ob_we, out_fire;
	logic [CW-1:0] raddr_full;
	logic [AW-1:0] raw_addr;
	logic [CW:0]   fnext;
	logic [2:0]    dec_n;
	logic [20:0]   dec_cp, d2, d3, d4, pt_wd, sh_wd;
	logic          ok2, ok3, ok4, latin, sub_end, single;
	logic [1:0]    slen;
	logic [7:0]    sch;
	logic [PW-1:0] np_nx, sh_wa;
	logic [CW-1:0] pos_adv;
	logic          a_ok, space, cn_new, cp_new;
	logic [5:0]    a_idx;
	logic [1:0]    llen;
	logic [7:0]    enc_b;

	assign raw_we     = cmd.load && (cnt_q < RAWN);
	assign raddr_full = pos_q + CW'(fk_q);
	assign raw_addr   = raddr_full[AW-1:0];
	assign fnext      = (CW + 1)'(pos_q) + (CW + 1)'(fk_q) + (CW + 1)'(1);
	assign out_fire   = out_valid_q && !out_stall;

	always_comb begin
		d2  = {10'b0, w_q[0][4:0], w_q[1][5:0]};
		d3  = {5'b0, w_q[0][3:0], w_q[1][5:0], w_q[2][5:0]};
		d4  = {w_q[0][2:0], w_q[1][5:0], w_q[2][5:0], w_q[3][5:0]};
		ok2 = (w_q[0][7:5] == 3'b110) && (nav_q >= 3'd2) && cont(w_q[1]) && (d2 >= 21'h80);
		ok3 = (w_q[0][7:4] == 4'hE) && (nav_q >= 3'd3) && cont(w_q[1]) && cont(w_q[2]) &&
			(d3 >= 21'h800);
		ok4 = (w_q[0][7:3] == 5'b11110) && (nav_q >= 3'd4) && cont(w_q[1]) &&
			cont(w_q[2]) && cont(w_q[3]) && (d4 >= 21'h10000) && (d4 <= 21'h10FFFF);
		dec_n  = 3'd0;
		dec_cp = {13'b0, w_q[0]};
		if (!w_q[0][7]) begin
			dec_n = 3'd1;
		end else if (ok2) begin
			dec_n = 3'd2;
			dec_cp = d2;
		end else if (ok3) begin
			dec_n = 3'd3;
			dec_cp = d3;
		end else if (ok4) begin
			dec_n = 3'd4;
			dec_cp = d4;
		end
		latin   = w_q[0] >= 8'hA0;
		single  = (dec_n != 3'd0) || latin;
		slen    = sub_len(w_q[0]);
		sch     = sub_char(w_q[0], sub_q);
		np_nx   = np_q + 1'b1;
		sub_end = (sub_q == slen - 2'd1) || (np_nx >= LIM);
		pos_adv = pos_q + CW'((dec_n != 3'd0) ? dec_n : 3'd1);
		if (dec_n != 3'd0) pt_wd = font_fix(dec_cp);
		else if (latin) pt_wd = {13'b0, w_q[0]};
		else pt_wd = {13'b0, sch};
	end

	assign pt_we = cmd.dec_step;

	always_comb begin
		a_ok  = 1'b0;
		a_idx = 6'd0;
		if (pt_rd_q >= 21'h621 && pt_rd_q <= 21'h63A) begin
			a_ok  = 1'b1;
			a_idx = 6'(pt_rd_q - 21'h621);
		end else if (pt_rd_q >= 21'h641 && pt_rd_q <= 21'h64A) begin
			a_ok  = 1'b1;
			a_idx = 6'(pt_rd_q - 21'h641 + 21'd26);
		end
		space  = pt_rd_q == SPACE;
		cn_new = nf4(pk_q) && a_ok && (a_idx != 6'd0);
		cp_new = (a_idx != 6'd0) && nf4(pk_q);
		sh_we  = cmd.run_end || (cmd.scan_step && in_run_q && (a_ok || space));
		sh_wa  = ppos_q;
		sh_wd  = shape(pk_q, pcp_q, 1'b0);
		if (cmd.scan_step && a_ok) begin
			sh_wd = shape(pk_q, pcp_q, cn_new);
		end else if (cmd.scan_step) begin
			sh_wa = rl_q;
			sh_wd = SPACE;
		end
		llen  = enc_len(enc_q);
		enc_b = enc_byte(enc_q, llen, bidx_q);
		ob_we = cmd.enc_step && (ol_q < LIM);
	end

	always_ff @(posedge clk) begin
		if (raw_we) raw_mem[cnt_q[AW-1:0]] <= in_byte;
		raw_rd_q <= raw_mem[raw_addr];
		if (pt_we) pt_mem[np_q] <= pt_wd;
		pt_rd_q <= pt_mem[i_q];
		if (sh_we) sh_mem[sh_wa] <= sh_wd;
		sh_rd_q <= sh_mem[ridx_q];
		if (ob_we) ob_mem[ol_q] <= enc_b;
		ob_rd_q <= ob_mem[oi_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch_cap) w_q[fk_q] <= raw_rd_q;
		if (cmd.scan_step && a_ok) begin
			pk_q   <= a_idx;
			pcp_q  <= in_run_q ? cp_new : 1'b0;
			ppos_q <= in_run_q ? rl_q : '0;
		end
		if (cmd.scan_step && !in_run_q && !a_ok) enc_q <= font_fix(pt_rd_q);
		if (cmd.run_ld) enc_q <= font_fix(sh_rd_q);
		if (cmd.out_ld) begin
			out_byte_q <= ob_rd_q;
			out_last_q <= oi_q == ol_q - 1'b1;
			failed_q   <= 1'b0;
		end
		if (cmd.fail_ld) begin
			out_byte_q <= 8'h00;
			out_last_q <= 1'b1;
			failed_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			overrun_q   <= 1'b0;
			pos_q       <= '0;
			fk_q        <= '0;
			nav_q       <= '0;
			sub_q       <= '0;
			np_q        <= '0;
			i_q         <= '0;
			rl_q        <= '0;
			ridx_q      <= '0;
			ol_q        <= '0;
			oi_q        <= '0;
			bidx_q      <= '0;
			in_run_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (cnt_q < RAWN) cnt_q <= cnt_q + 1'b1;
				else overrun_q <= 1'b1;
			end
			if (cmd.conv_init) begin
				pos_q    <= '0;
				fk_q     <= '0;
				sub_q    <= '0;
				np_q     <= '0;
				i_q      <= '0;
				ol_q     <= '0;
				oi_q     <= '0;
				in_run_q <= 1'b0;
			end
			if (cmd.fetch_cap) begin
				nav_q <= 3'(fk_q) + 3'd1;
				fk_q  <= fk_q + 2'd1;
			end
			if (cmd.dec_step) begin
				np_q <= np_nx;
				if (single) begin
					pos_q <= pos_adv;
					fk_q  <= '0;
				end else if (sub_end) begin
					pos_q <= pos_q + 1'b1;
					sub_q <= '0;
					fk_q  <= '0;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end
			if (cmd.scan_step) begin
				if (in_run_q) begin
					if (a_ok || space) begin
						rl_q <= rl_q + 1'b1;
						i_q  <= i_q + 1'b1;
					end
				end else begin
					i_q <= i_q + 1'b1;
					if (a_ok) begin
						rl_q     <= PW'(1);
						in_run_q <= 1'b1;
					end else begin
						bidx_q <= '0;
					end
				end
			end
			if (cmd.run_end) ridx_q <= rl_q - 1'b1;
			if (cmd.run_ld) bidx_q <= '0;
			if (ob_we) begin
				ol_q <= ol_q + 1'b1;
				if (bidx_q == llen) begin
					bidx_q <= '0;
					if (in_run_q) begin
						if (ridx_q == '0) in_run_q <= 1'b0;
						else ridx_q <= ridx_q - 1'b1;
					end
				end else begin
					bidx_q <= bidx_q + 2'd1;
				end
			end
			if (cmd.out_ld || cmd.fail_ld) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
			if (cmd.out_next) oi_q <= oi_q + 1'b1;
			if (cmd.out_done) begin
				cnt_q     <= '0;
				overrun_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.overrun     = overrun_q;
		sts.dec_go      = (pos_q < cnt_q) && (np_q < LIM);
		sts.fetch_done  = (fk_q == 2'd3) || (fnext >= (CW + 1)'(cnt_q));
		sts.dec_cont    = !single && !sub_end;
		sts.scan_go     = i_q < np_q;
		sts.in_run      = in_run_q;
		sts.pt_arabic   = a_ok;
		sts.pt_space    = space;
		sts.enc_full    = ol_q >= LIM;
		sts.enc_last    = bidx_q == llen;
		sts.ridx_zero   = ridx_q == '0;
		sts.ol_zero     = ol_q == '0;
		sts.out_is_last = out_last_q;
		sts.out_fire    = out_fire;
	end

	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign failed    = failed_q;
	assign out_valid = out_valid_q;

endmodule

@@ design/utf8_display_sanitizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_display_sanitizer
// Turns the raw bytes of one text field into display-safe UTF-8 with Arabic
// runs shaped and reversed.
//
// The input channel takes one word per cycle (in_byte, last_byte) while the
// block is loading; last_byte closes the field and starts conversion, during
// which in_stall stays high. Conversion reads the raw byte store up to four
// times per decoder window and then decodes the window, with a further
// decode step per extra substitute character; it then scans the code points
// for shaping, ends each Arabic run and reads the run back reversed, and
// encodes each code point into its UTF-8 bytes in the output buffer.
// Each output word then passes through the output buffer read port and the
// output register. A field ends with a word carrying out_last; an overlong
// field, an overlong output or an empty output gives the single word with
// failed set. The output register holds its word while out_stall is high,
// and loading resumes the cycle after the final word is taken. Reset
// empties the field and the output register; the stores need no clearing.
// ----------------------------------------------------------------------------
module utf8_display_sanitizer #(
	parameter int LINE_MAX  = 64,
	parameter int RAW_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       failed
);
	import uds_pkg::*;

	uds_cmd_t cmd;
	uds_sts_t sts;

	uds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	uds_dp #(
		.LINE_MAX  (LINE_MAX),
		.RAW_BYTES (RAW_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.failed    (failed),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while an output word is pending");

	a_fail_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> (out_last && out_byte == 8'h00))
		else $error("failure word malformed");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_last) |=> (!in_stall && !out_valid))
		else $error("block did not return to loading after the final word");

endmodule

@@ bench/tb_utf8_display_sanitizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_display_sanitizer
// Self-checking bench for the display sanitiser. Whole text fields are sent a
// word at a time with random gaps, and the output side stalls at random. A
// behavioural model of the conversion predicts every output word. Directed
// fields cover the decoder corners, the substitutes, shaping and the limits.
// Random fields then mix well-formed UTF-8, Arabic runs and raw noise.
// ----------------------------------------------------------------------------
module tb_utf8_display_sanitizer;
	import uds_pkg::*;

	localparam int LINE_MAX   = 64;
	localparam int RAW_BYTES  = 256;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 200;

	typedef struct {
		logic [7:0] data;
		logic       fin;
		logic       fail;
	} disp_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       failed;

	disp_word_t disp_expected[$];
	logic [7:0] field_bytes[$];
	int         points[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         sent_bytes = 0;
	bit         calm = 1'b0;

	localparam logic [15:0] AR_ISO[36] = '{
		16'hFE80, 16'hFE81, 16'hFE83, 16'hFE85, 16'hFE87, 16'hFE89, 16'hFE8D, 16'hFE8F,
		16'hFE93, 16'hFE95, 16'hFE99, 16'hFE9D, 16'hFEA1, 16'hFEA5, 16'hFEA9, 16'hFEAB,
		16'hFEAD, 16'hFEAF, 16'hFEB1, 16'hFEB5, 16'hFEB9, 16'hFEBD, 16'hFEC1, 16'hFEC5,
		16'hFEC9, 16'hFECD, 16'hFED1, 16'hFED5, 16'hFED9, 16'hFEDD, 16'hFEE1, 16'hFEE5,
		16'hFEE9, 16'hFEED, 16'hFEEF, 16'hFEF1
	};
	localparam int AR_FORMS[36] = '{
		1, 2, 2, 2, 2, 4, 2, 4, 2, 4, 4, 4, 4, 4, 2, 2, 2, 2,
		4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 2, 2, 4
	};

	utf8_display_sanitizer #(.LINE_MAX(LINE_MAX), .RAW_BYTES(RAW_BYTES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .out_last(out_last), .failed(failed)
	);

	always #5 clk = ~clk;

	function automatic int arabic_index(int c);
		if (c >= 'h621 && c <= 'h63A) return c - 'h621;
		if (c >= 'h641 && c <= 'h64A) return c - 'h641 + 26;
		return -1;
	endfunction

	function automatic bit font_has(int c);
		return (c >= 'h20 && c <= 'h7E) || (c >= 'h80 && c <= 'h24F) ||
			(c >= 'h370 && c <= 'h4FF) || (c >= 'h3000 && c <= 'h30FF) ||
			(c >= 'h4E00 && c <= 'h9FEF) || (c >= 'h20000 && c <= 'h200CC) ||
			(c >= 'hAC00 && c <= 'hD7A3) || (c >= 'h600 && c <= 'h6FF) ||
			(c >= 'h750 && c <= 'h77F) || (c >= 'h8A0 && c <= 'h8FF) ||
			(c >= 'hFB50 && c <= 'hFDFF) || (c >= 'hFE70 && c <= 'hFEFF);
	endfunction

	function automatic string c1_substitute(int b);
		case (b)
			'h80: return "EUR";
			'h82: return ",";
			'h83: return "f";
			'h84, 'h93, 'h94: return "\"";
			'h85: return "...";
			'h86, 'h87: return "+";
			'h89: return "%";
			'h8B, 'h9B: return "<";
			'h91, 'h92: return "'";
			'h96, 'h97: return "-";
			default: return "?";
		endcase
	endfunction

	function automatic bit is_cont(logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic int decode_len(int pos, output int cp);
		int len;
		int b0;
		int d;
		len = field_bytes.size();
		b0 = field_bytes[pos];
		cp = 0;
		if (b0 < 'h80) begin
			cp = b0;
			return 1;
		end
		if ((b0 & 'hE0) == 'hC0 && pos + 1 < len && is_cont(field_bytes[pos+1])) begin
			d = ((b0 & 'h1F) << 6) | (field_bytes[pos+1] & 'h3F);
			if (d >= 'h80) begin
				cp = d;
				return 2;
			end
		end
		if ((b0 & 'hF0) == 'hE0 && pos + 2 < len && is_cont(field_bytes[pos+1]) &&
				is_cont(field_bytes[pos+2])) begin
			d = ((b0 & 'h0F) << 12) | ((field_bytes[pos+1] & 'h3F) << 6) |
				(field_bytes[pos+2] & 'h3F);
			if (d >= 'h800) begin
				cp = d;
				return 3;
			end
		end
		if ((b0 & 'hF8) == 'hF0 && pos + 3 < len && is_cont(field_bytes[pos+1]) &&
				is_cont(field_bytes[pos+2]) && is_cont(field_bytes[pos+3])) begin
			d = ((b0 & 'h07) << 18) | ((field_bytes[pos+1] & 'h3F) << 12) |
				((field_bytes[pos+2] & 'h3F) << 6) | (field_bytes[pos+3] & 'h3F);
			if (d >= 'h10000 && d <= 'h10FFFF) begin
				cp = d;
				return 4;
			end
		end
		return 0;
	endfunction

	function automatic void utf8_append(ref logic [7:0] q[$], input int c);
		if (c < 'h80) begin
			q.push_back(c[7:0]);
		end else if (c < 'h800) begin
			q.push_back(8'hC0 | c[10:6]);
			q.push_back(8'h80 | c[5:0]);
		end else if (c < 'h10000) begin
			q.push_back(8'hE0 | c[15:12]);
			q.push_back(8'h80 | c[11:6]);
			q.push_back(8'h80 | c[5:0]);
		end else begin
			q.push_back(8'hF0 | c[20:18]);
			q.push_back(8'h80 | c[17:12]);
			q.push_back(8'h80 | c[11:6]);
			q.push_back(8'h80 | c[5:0]);
		end
	endfunction

	function automatic int shaped_form(int j, int s, int e);
		int k;
		int pp;
		int nn;
		int pk;
		int nk;
		bit jp;
		bit jn;
		k = arabic_index(points[j]);
		if (k < 0) return points[j];
		pp = j - 1;
		nn = j + 1;
		pk = -1;
		nk = -1;
		while (pp >= s && points[pp] == 'h20) pp--;
		while (nn < e && points[nn] == 'h20) nn++;
		if (pp >= s) pk = arabic_index(points[pp]);
		if (nn < e) nk = arabic_index(points[nn]);
		jp = AR_FORMS[k] >= 2 && pk >= 0 && AR_FORMS[pk] == 4;
		jn = AR_FORMS[k] == 4 && nk >= 0 && AR_FORMS[nk] >= 2;
		if (jp && jn) return AR_ISO[k] + 3;
		if (jp) return AR_ISO[k] + 1;
		if (jn) return AR_ISO[k] + 2;
		return AR_ISO[k];
	endfunction

	function automatic void sanitise_field(ref disp_word_t words[$]);
		logic [7:0] text[$];
		int pos;
		int n;
		int cp;
		int b0;
		int i;
		int e;
		int j;
		string sub;
		words.delete();
		points.delete();
		if (field_bytes.size() > RAW_BYTES) begin
			words.push_back('{8'h00, 1'b1, 1'b1});
			return;
		end
		pos = 0;
		while (pos < field_bytes.size() && points.size() < LINE_MAX - 1) begin
			b0 = field_bytes[pos];
			n = decode_len(pos, cp);
			if (n != 0) begin
				points.push_back(font_has(cp) ? cp : 'h3F);
				pos += n;
			end else if (b0 >= 'hA0) begin
				points.push_back(font_has(b0) ? b0 : 'h3F);
				pos++;
			end else begin
				sub = c1_substitute(b0);
				for (j = 0; j < sub.len() && points.size() < LINE_MAX - 1; j++)
					points.push_back(sub[j]);
				pos++;
			end
		end
		i = 0;
		while (i < points.size()) begin
			if (arabic_index(points[i]) >= 0) begin
				e = i + 1;
				while (e < points.size() && (points[e] == 'h20 || arabic_index(points[e]) >= 0))
					e++;
				for (j = e - 1; j >= i; j--) begin
					cp = shaped_form(j, i, e);
					utf8_append(text, font_has(cp) ? cp : 'h3F);
				end
				i = e;
			end else begin
				utf8_append(text, font_has(points[i]) ? points[i] : 'h3F);
				i++;
			end
		end
		if (text.size() > LINE_MAX - 1 || text.size() == 0) begin
			words.push_back('{8'h00, 1'b1, 1'b1});
			return;
		end
		foreach (text[k])
			words.push_back('{text[k], k == text.size() - 1, 1'b0});
	endfunction

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 18);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		last_byte <= fin;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_field();
		disp_word_t words[$];
		sanitise_field(words);
		foreach (field_bytes[k]) begin
			send_word(field_bytes[k], k == field_bytes.size() - 1);
			if (k == field_bytes.size() - 1)
				foreach (words[w]) disp_expected.push_back(words[w]);
		end
		field_bytes.delete();
	endtask

	task automatic send_points(input int cps[$]);
		foreach (cps[k]) utf8_append(field_bytes, cps[k]);
		send_field();
	endtask

	task automatic test_ascii();
		send_points('{'h20, 'h41, 'h7E, 'h00, 'h7F, 'h0A});
		field_bytes = '{8'h5A};
		send_field();
	endtask

	task automatic test_multibyte();
		send_points('{'hE9, 'h3B1, 'h4E2D, 'hAC00, 'hD7A3, 'h30A2, 'h200CC, 'h20000});
		// Out of the font: CJK extension, emoji, a surrogate and the top code point.
		field_bytes = '{8'hED, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		utf8_append(field_bytes, 'h1F600);
		utf8_append(field_bytes, 'h9FF0);
		send_field();
	endtask

	task automatic test_invalid();
		// Overlong forms, a code point above the top, and a truncated sequence.
		field_bytes = '{8'hC0, 8'hAF, 8'hE0, 8'h80, 8'hAF, 8'hF0, 8'h80, 8'h80, 8'hAF,
			8'hF4, 8'h90, 8'h80, 8'h80, 8'hE4, 8'hB8};
		send_field();
		field_bytes = '{8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h89, 8'h8B,
			8'h91, 8'h92, 8'h93, 8'h94, 8'h96, 8'h97, 8'h9B, 8'h81, 8'h9F};
		send_field();
		field_bytes = '{8'hA0, 8'hFF, 8'hC3, 8'hF8, 8'hBF};
		send_field();
	endtask

	task automatic test_arabic();
		send_points('{'h644, 'h627, 'h20, 'h628, 'h64A, 'h62A, 'h41, 'h621, 'h647, 'h20});
		send_points('{'h20, 'h643, 'h20, 'h20, 'h645, 'h648, 'h660, 'h62F, 'h631, 'h64A});
	endtask

	task automatic test_limits();
		// Substitutes cut off at the point limit give exactly the longest output.
		repeat (22) field_bytes.push_back(8'h85);
		send_field();
		// A two-byte first point pushes the same output one byte over.
		field_bytes.push_back(8'hFF);
		repeat (21) field_bytes.push_back(8'h85);
		send_field();
	endtask

	function automatic int random_point();
		case ($urandom_range(0, 7))
			0: return $urandom_range('h20, 'h7E);
			1: return $urandom_range('h80, 'h7FF);
			2: return $urandom_range('h800, 'hFFFF);
			3: return $urandom_range('h10000, 'h10FFFF);
			4: return $urandom_range('h20000, 'h200CC);
			5: return $urandom_range(0, 1) ? 'h20 : $urandom_range('h600, 'h6FF);
			default: return $urandom_range(0, 1) ? $urandom_range('h621, 'h63A)
				: $urandom_range('h641, 'h64A);
		endcase
	endfunction

	task automatic test_random();
		int len;
		int kind;
		while (sent_bytes < 175) begin
			calm = $urandom_range(0, 4) == 0;
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 10);
			repeat (len) begin
				if (kind < 7) utf8_append(field_bytes, random_point());
				else field_bytes.push_back($urandom_range(0, 255));
			end
			if (kind == 6 && field_bytes.size() > 1)
				field_bytes[$urandom_range(0, field_bytes.size() - 1)] = $urandom_range(0, 255);
			send_field();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_ascii();
		test_multibyte();
		test_invalid();
		test_arabic();
		test_limits();
		test_random();
		in_valid <= 1'b0;
		while (disp_expected.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int hold;
		forever begin
			@(negedge clk);
			hold = draw_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			forever begin
				@(posedge clk);
				if (out_valid) break;
			end
		end
	end

	always @(posedge clk) begin
		disp_word_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (disp_expected.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: byte %h last %b failed %b",
							out_byte, out_last, failed);
					mismatches <= mismatches + 1;
				end else begin
					want = disp_expected.pop_front();
					if (out_byte !== want.data || out_last !== want.fin ||
							failed !== want.fail) begin
						if (mismatches < 10)
							$display("mismatch: expected %h/%b/%b got %h/%b/%b",
								want.data, want.fin, want.fail, out_byte, out_last, failed);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

@@ files.f @@
design/uds_pkg.sv
design/uds_ctrl.sv
design/uds_dp.sv
design/utf8_display_sanitizer.sv
bench/tb_utf8_display_sanitizer.sv
